/* design/bflc_pkg.sv */
// ----------------------------------------------------------------------------
// Bit set with lazy flip: shared package
// Types, opcodes and size constants used by the bit set modules.
// ----------------------------------------------------------------------------
package bflc_pkg;

	// Default sizes of the set and of one storage word.
	localparam int MAX_BITS_DEF  = 1024;
	localparam int WORD_BITS_DEF = 32;

	// Field widths fixed by the command and result formats.
	localparam int IDX_W = 10;
	localparam int CNT_W = 11;

	// Size of the set after reset, before any clamp to the store size.
	localparam int BIT_COUNT_RESET = 1024;

	// Width of the byte address on the configuration port.
	localparam int ADDR_W = 3;

	// Command opcodes.
	typedef enum logic [1:0] {
		OP_SET   = 2'd0,
		OP_CLEAR = 2'd1,
		OP_FLIP  = 2'd2,
		OP_QUERY = 2'd3
	} opcode_t;

	// Register indexes on the configuration port.
	typedef enum logic [0:0] {
		REG_BIT_COUNT = 1'b0,
		REG_UNUSED    = 1'b1
	} reg_idx_t;

	// One command.
	typedef struct packed {
		opcode_t          opcode;
		logic [IDX_W-1:0] bit_index;
	} cmd_t;

	// One result.
	typedef struct packed {
		logic [CNT_W-1:0] ones_count;
		logic             all_ones;
		logic             any_one;
		logic             index_error;
	} result_t;

endpackage

/* design/bflc_word_mem.sv */
// ----------------------------------------------------------------------------
// Bit set word store
// Single-clock memory with one write port and one registered read port.
// A read and a write of the same word in one cycle return the old word.
// ----------------------------------------------------------------------------
module bflc_word_mem #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 32,
	parameter int AW    = 5
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* design/bflc_clear_seq.sv */
// ----------------------------------------------------------------------------
// Bit set clearing sequencer
// Walks the word store one address per cycle after reset and after every
// restart request, so that the store can be written with zeros.
// ----------------------------------------------------------------------------
module bflc_clear_seq #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          restart,
	output logic          active,
	output logic [AW-1:0] addr
);

	logic          active_q;
	logic [AW-1:0] cnt_q;
	logic          last;

	assign last = (cnt_q == AW'(DEPTH - 1));

	// Address counter; a restart begins the pass again from the first word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b1;
			cnt_q    <= '0;
		end else if (restart) begin
			active_q <= 1'b1;
			cnt_q    <= '0;
		end else if (active_q) begin
			if (last) begin
				active_q <= 1'b0;
				cnt_q    <= '0;
			end else begin
				cnt_q <= cnt_q + AW'(1);
			end
		end
	end

	assign active = active_q;
	assign addr   = cnt_q;

endmodule

/* design/bitset_lazy_flip_counter.sv */
// ----------------------------------------------------------------------------
// Bit set with lazy flip and ones counter
// Set, clear, flip-all and query on a bit set held in a word memory, with an
// invert flag and a running count of logical ones.
//
//   Channel   Signals                                   Direction  Flow
//   command   start, busy, cmd (opcode, bit_index)      in         start & !busy
//   result    done, result (count and flags)            out        one cycle strobe
//   config    psel, penable, pwrite, paddr, pwdata,     in/out     APB, no wait
//             prdata, pready
//
// A command is accepted in any cycle where busy is low, one per cycle.
// Its result is registered in stage 1 and then in the result registers, where it
// is driven with done; nothing can stall it on the way.
// The word memory is read when the command is accepted and written back in the
// cycle after; a write to the word just read is forwarded to the next command.
// After reset and after every write of bit_count, busy stays high while the
// store (MAX_BITS/WORD_BITS words, rounded up) is cleared one word a cycle.
// The receiver of results cannot stall the block.
// ----------------------------------------------------------------------------
module bitset_lazy_flip_counter #(
	parameter int MAX_BITS  = bflc_pkg::MAX_BITS_DEF,
	parameter int WORD_BITS = bflc_pkg::WORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// Command channel
	input  logic                         start,
	output logic                         busy,
	input  bflc_pkg::cmd_t               cmd,
	// Result channel
	output logic                         done,
	output bflc_pkg::result_t            result,
	// Configuration port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [bflc_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);

	// WORD_BITS is a power of two.
	localparam int WORD_COUNT = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
	localparam int AW         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
	localparam int BW         = $clog2(WORD_BITS);
	localparam int IDX_W      = bflc_pkg::IDX_W;
	localparam int CNT_W      = bflc_pkg::CNT_W;
	localparam int CNT_LIMIT  = (1 << CNT_W) - 1;
	localparam int CNT_MAX    = (MAX_BITS > CNT_LIMIT) ? CNT_LIMIT : MAX_BITS;
	localparam int CNT_RST    = (bflc_pkg::BIT_COUNT_RESET > CNT_MAX) ?
	                            CNT_MAX : bflc_pkg::BIT_COUNT_RESET;

	// Configuration state and the set's scalar state.
	logic [CNT_W-1:0]     bit_count_q;
	logic [CNT_W-1:0]     ones_q;
	logic                 invert_q;

	// Command in the read-modify-write stage.
	logic                 valid_s1;
	bflc_pkg::opcode_t    op_s1;
	logic [IDX_W-1:0]     idx_s1;

	// Last word written, kept for forwarding.
	logic                 fwd_valid_q;
	logic [AW-1:0]        fwd_addr_q;
	logic [WORD_BITS-1:0] fwd_data_q;

	// Result registers.
	logic                 done_q;
	bflc_pkg::result_t    result_q;

	logic                 accept;
	logic                 cfg_write;
	logic [CNT_W-1:0]     wr_raw;
	logic [CNT_W-1:0]     wr_count;
	logic                 clr_active;
	logic [AW-1:0]        clr_addr;

	logic [AW+IDX_W-1:0]  rd_word_wide;
	logic [AW+IDX_W-1:0]  s1_word_wide;
	logic [AW-1:0]        rd_addr;
	logic [AW-1:0]        addr_s1;
	logic [BW-1:0]        bit_s1;
	logic [WORD_BITS-1:0] mem_rdata;
	logic [WORD_BITS-1:0] word_s1;
	logic                 is_setclr;
	logic                 idx_err;
	logic                 logical;
	logic                 target;
	logic                 change;
	logic [CNT_W-1:0]     ones_next;
	logic [WORD_BITS-1:0] upd_data;

	logic                 mem_we;
	logic [AW-1:0]        mem_waddr;
	logic [WORD_BITS-1:0] mem_wdata;

	assign accept    = start && !busy;
	assign cfg_write = psel && penable && pwrite && pready &&
	                   (bflc_pkg::reg_idx_t'(paddr[2]) == bflc_pkg::REG_BIT_COUNT);

	// Clamp a written size into 1..CNT_MAX, the smaller of MAX_BITS and 2047.
	assign wr_raw = pwdata[CNT_W-1:0];
	always_comb begin
		if (wr_raw == '0) begin
			wr_count = CNT_W'(1);
		end else if (32'(wr_raw) > CNT_MAX) begin
			wr_count = CNT_W'(CNT_MAX);
		end else begin
			wr_count = wr_raw;
		end
	end

	// Configuration port: no wait states, reads return the size register, or zero at the unused address.
	assign pready = 1'b1;
	assign prdata = (bflc_pkg::reg_idx_t'(paddr[2]) == bflc_pkg::REG_BIT_COUNT) ?
	                {{(32-CNT_W){1'b0}}, bit_count_q} : '0;

	// Word address and bit position of the command at accept and in stage 1.
	assign rd_word_wide = {{AW{1'b0}}, cmd.bit_index} >> BW;
	assign rd_addr      = rd_word_wide[AW-1:0];
	assign s1_word_wide = {{AW{1'b0}}, idx_s1} >> BW;
	assign addr_s1      = s1_word_wide[AW-1:0];
	assign bit_s1       = idx_s1[BW-1:0];

	// Stored word, taking the previous write when it hit the same word.
	assign word_s1 = (fwd_valid_q && (fwd_addr_q == addr_s1)) ? fwd_data_q : mem_rdata;

	// Set or clear decision and the new ones count.
	always_comb begin
		is_setclr = (op_s1 == bflc_pkg::OP_SET) || (op_s1 == bflc_pkg::OP_CLEAR);
		idx_err   = is_setclr && ({1'b0, idx_s1} >= bit_count_q);
		logical   = word_s1[bit_s1] ^ invert_q;
		target    = (op_s1 == bflc_pkg::OP_SET);
		change    = is_setclr && !idx_err && (logical != target);
		upd_data  = word_s1 ^ (WORD_BITS'(1) << bit_s1);
		if (change) begin
			ones_next = target ? (ones_q + CNT_W'(1)) : (ones_q - CNT_W'(1));
		end else if (op_s1 == bflc_pkg::OP_FLIP) begin
			ones_next = bit_count_q - ones_q;
		end else begin
			ones_next = ones_q;
		end
	end

	// Memory write: the clearing pass owns the port while it runs.
	always_comb begin
		if (clr_active) begin
			mem_we    = 1'b1;
			mem_waddr = clr_addr;
			mem_wdata = '0;
		end else begin
			mem_we    = valid_s1 && change;
			mem_waddr = addr_s1;
			mem_wdata = upd_data;
		end
	end

	bflc_word_mem #(
		.DEPTH(WORD_COUNT),
		.WIDTH(WORD_BITS),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (accept),
		.raddr(rd_addr),
		.rdata(mem_rdata)
	);

	bflc_clear_seq #(
		.DEPTH(WORD_COUNT),
		.AW   (AW)
	) u_clear (
		.clk    (clk),
		.arst_n (arst_n),
		.restart(cfg_write),
		.active (clr_active),
		.addr   (clr_addr)
	);

	assign busy = clr_active;

	// Size register, invert flag and ones count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_count_q <= CNT_W'(CNT_RST);
			ones_q      <= '0;
			invert_q    <= 1'b0;
		end else if (cfg_write) begin
			bit_count_q <= wr_count;
			ones_q      <= '0;
			invert_q    <= 1'b0;
		end else if (valid_s1) begin
			ones_q <= ones_next;
			if (op_s1 == bflc_pkg::OP_FLIP) begin
				invert_q <= !invert_q;
			end
		end
	end

	// Stage 1 control, the forwarding entry and the result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			fwd_valid_q <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			valid_s1    <= accept;
			fwd_valid_q <= !clr_active && valid_s1 && change;
			done_q      <= valid_s1;
		end
	end

	// Stage 1 payload, forwarded word and result payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1  <= cmd.opcode;
			idx_s1 <= cmd.bit_index;
		end
		fwd_addr_q <= addr_s1;
		fwd_data_q <= upd_data;
		if (valid_s1) begin
			result_q.ones_count  <= ones_next;
			result_q.all_ones    <= (ones_next == bit_count_q);
			result_q.any_one     <= (ones_next != '0);
			result_q.index_error <= idx_err;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	// Every accepted command gives exactly one result.
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> ##1 done)
		else $error("accepted command produced no result");

	a_done_has_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 2))
		else $error("result without an accepted command");

	// The ones count never exceeds the size of the set.
	a_ones_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ones_q <= bit_count_q)
		else $error("ones count above bit count");

	// A command write-back never happens while the store is being cleared.
	a_no_update_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_active |-> !(valid_s1 && change))
		else $error("update write during clearing pass");

endmodule

/* tb/tb_bitset_lazy_flip_counter.sv */
// ----------------------------------------------------------------------------
// Testbench for the bit set with lazy flip and ones counter
// Drives set, clear, flip and query commands and several set sizes through
// the block. A shadow copy of the set, flag and count predicts each result,
// which is checked field by field as it comes out.
// ----------------------------------------------------------------------------
module tb_bitset_lazy_flip_counter;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WORDS         = bflc_pkg::MAX_BITS_DEF / bflc_pkg::WORD_BITS_DEF;
	localparam int SETTLE_CYCLES = 4;
	localparam int CYCLE_LIMIT   = 200_000;
	localparam int BATCH_ITEMS   = 100;
	localparam int IDX_W         = bflc_pkg::IDX_W;
	localparam int CNT_W         = bflc_pkg::CNT_W;

	logic                        clk     = 1'b0;
	logic                        arst_n  = 1'b0;
	logic                        start   = 1'b0;
	logic                        busy;
	bflc_pkg::cmd_t              cmd     = '0;
	logic                        done;
	bflc_pkg::result_t           result;
	logic                        psel    = 1'b0;
	logic                        penable = 1'b0;
	logic                        pwrite  = 1'b0;
	logic [bflc_pkg::ADDR_W-1:0] paddr   = '0;
	logic [31:0]                 pwdata  = '0;
	logic [31:0]                 prdata;
	logic                        pready;

	// Shadow copy of the set as the block should hold it.
	logic [bflc_pkg::WORD_BITS_DEF-1:0] shadow_words [WORDS];
	logic                               shadow_invert;
	int unsigned                        shadow_ones;
	int unsigned                        shadow_size;

	bflc_pkg::cmd_t    cmd_q [$];
	bflc_pkg::result_t expected_status [$];
	logic              cmd_taken = 1'b0;
	int unsigned       gap_left  = 0;
	bit                idle_on   = 1'b1;
	int unsigned       mismatches = 0;
	int unsigned       cycles     = 0;

	bitset_lazy_flip_counter dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.cmd     (cmd),
		.done    (done),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// A written size of zero means one bit; anything past the store is the store.
	function automatic int unsigned clamp_size(int unsigned v);
		if (v == 0)
			return 1;
		if (v > bflc_pkg::MAX_BITS_DEF)
			return bflc_pkg::MAX_BITS_DEF;
		return v;
	endfunction

	function automatic void clear_shadow();
		foreach (shadow_words[i])
			shadow_words[i] = '0;
		shadow_invert = 1'b0;
		shadow_ones   = 0;
	endfunction

	// Applies one command to the shadow set and returns the status it should give.
	function automatic bflc_pkg::result_t track_command(bflc_pkg::cmd_t c);
		bflc_pkg::result_t r;
		int unsigned       w;
		int unsigned       b;
		logic              target;
		r = '0;
		if (c.opcode == bflc_pkg::OP_SET || c.opcode == bflc_pkg::OP_CLEAR) begin
			if (c.bit_index >= shadow_size) begin
				r.index_error = 1'b1;
			end else begin
				target = (c.opcode == bflc_pkg::OP_SET);
				w = c.bit_index / bflc_pkg::WORD_BITS_DEF;
				b = c.bit_index % bflc_pkg::WORD_BITS_DEF;
				// Stored bits are seen through the invert flag.
				if ((shadow_words[w][b] ^ shadow_invert) != target) begin
					shadow_words[w][b] = ~shadow_words[w][b];
					if (target)
						shadow_ones++;
					else
						shadow_ones--;
				end
			end
		end else if (c.opcode == bflc_pkg::OP_FLIP) begin
			shadow_invert = ~shadow_invert;
			shadow_ones   = shadow_size - shadow_ones;
		end
		r.ones_count = shadow_ones[CNT_W-1:0];
		r.all_ones   = (shadow_ones == shadow_size);
		r.any_one    = (shadow_ones != 0);
		return r;
	endfunction

	task automatic check_field(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Command driver: holds each command until its transfer, with random gaps.
	always @(negedge clk) begin
		if (!start || cmd_taken) begin
			if (gap_left != 0) begin
				start    <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (cmd_q.size() != 0) begin
				start <= 1'b1;
				cmd   <= cmd_q.pop_front();
				if (idle_on && $urandom_range(0, 3) == 0)
					gap_left <= $urandom_range(1, 4);
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: predicts on each command transfer and checks each result strobe.
	always @(posedge clk) begin
		bflc_pkg::result_t want;
		if (!arst_n) begin
			cmd_taken <= 1'b0;
		end else begin
			cmd_taken <= start && !busy;
			if (start && !busy)
				expected_status.insert(expected_status.size(), track_command(cmd));
			if (done) begin
				if (expected_status.size() == 0) begin
					$display("%0t: result with no command outstanding, expected none, actual %h",
						$time, result);
					mismatches++;
				end else begin
					want = expected_status.pop_front();
					check_field("ones_count", want.ones_count, result.ones_count);
					check_field("all_ones", CNT_W'(want.all_ones), CNT_W'(result.all_ones));
					check_field("any_one", CNT_W'(want.any_one), CNT_W'(result.any_one));
					check_field("index_error", CNT_W'(want.index_error),
						CNT_W'(result.index_error));
				end
			end
		end
	end

	// Run limit.
	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	task automatic add_cmd(bflc_pkg::opcode_t op, int unsigned idx);
		bflc_pkg::cmd_t c;
		c.opcode    = op;
		c.bit_index = IDX_W'(idx);
		cmd_q.insert(cmd_q.size(), c);
	endtask

	// Waits until every command has gone in and every result has come out.
	task automatic wait_idle();
		@(posedge clk);
		while (cmd_q.size() != 0 || start || expected_status.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One register write: setup cycle, then access cycle.
	task automatic write_reg(bflc_pkg::reg_idx_t idx, logic [31:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		// A size write starts a new empty set.
		if (idx == bflc_pkg::REG_BIT_COUNT) begin
			shadow_size = clamp_size(32'(data[CNT_W-1:0]));
			clear_shadow();
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// Random commands, mostly in range and often clustered so bits get revisited.
	task automatic queue_random(int unsigned n);
		bflc_pkg::cmd_t c;
		int unsigned    hot;
		int unsigned    pick;
		hot = $urandom_range(0, shadow_size - 1);
		repeat (n) begin
			pick = $urandom_range(0, 99);
			if (pick < 40)
				c.opcode = bflc_pkg::OP_SET;
			else if (pick < 70)
				c.opcode = bflc_pkg::OP_CLEAR;
			else if (pick < 85)
				c.opcode = bflc_pkg::OP_FLIP;
			else
				c.opcode = bflc_pkg::OP_QUERY;
			pick = $urandom_range(0, 99);
			if (pick < 45)
				c.bit_index = IDX_W'($urandom_range(0, shadow_size - 1));
			else if (pick < 80)
				c.bit_index = IDX_W'((hot + $urandom_range(0, 15)) % shadow_size);
			else if (pick < 85 && shadow_size < bflc_pkg::MAX_BITS_DEF)
				c.bit_index = IDX_W'(shadow_size);
			else
				c.bit_index = IDX_W'($urandom_range(0, (1 << IDX_W) - 1));
			cmd_q.insert(cmd_q.size(), c);
		end
	endtask

	// Stimulus sequence and final verdict.
	initial begin
		int unsigned sizes [$];
		clear_shadow();
		shadow_size = clamp_size(bflc_pkg::BIT_COUNT_RESET);
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Full size after reset: both ends, repeats, and flips in both senses.
		add_cmd(bflc_pkg::OP_SET, 0);
		add_cmd(bflc_pkg::OP_SET, 1023);
		add_cmd(bflc_pkg::OP_SET, 1023);
		add_cmd(bflc_pkg::OP_QUERY, 1023);
		add_cmd(bflc_pkg::OP_CLEAR, 1023);
		add_cmd(bflc_pkg::OP_FLIP, 512);
		add_cmd(bflc_pkg::OP_CLEAR, 0);
		add_cmd(bflc_pkg::OP_SET, 0);
		add_cmd(bflc_pkg::OP_FLIP, 0);
		add_cmd(bflc_pkg::OP_QUERY, 0);
		wait_idle();

		// A size of zero is taken as one bit; upper data bits are ignored.
		write_reg(bflc_pkg::REG_BIT_COUNT, 32'hFFFF_F800);
		add_cmd(bflc_pkg::OP_SET, 0);
		add_cmd(bflc_pkg::OP_SET, 1);
		add_cmd(bflc_pkg::OP_CLEAR, 1023);
		add_cmd(bflc_pkg::OP_FLIP, 1023);
		add_cmd(bflc_pkg::OP_FLIP, 0);
		add_cmd(bflc_pkg::OP_CLEAR, 0);
		add_cmd(bflc_pkg::OP_QUERY, 5);
		wait_idle();

		// Just below and at the size limit.
		write_reg(bflc_pkg::REG_BIT_COUNT, 32'd40);
		add_cmd(bflc_pkg::OP_SET, 39);
		add_cmd(bflc_pkg::OP_SET, 40);
		add_cmd(bflc_pkg::OP_FLIP, 40);
		add_cmd(bflc_pkg::OP_CLEAR, 39);
		queue_random(BATCH_ITEMS);
		wait_idle();

		// A write to the unused address must leave the set alone.
		write_reg(bflc_pkg::REG_UNUSED, $urandom());
		queue_random(BATCH_ITEMS / 2);

		sizes = '{2047, 1025, 7, 33, 1, 2, 1024, 32, 64, 0, 0};
		sizes[9]  = $urandom_range(3, 1023);
		sizes[10] = $urandom_range(1, 1024);
		foreach (sizes[i]) begin
			wait_idle();
			if (i == sizes.size() - 1)
				idle_on = 1'b0;
			write_reg(bflc_pkg::REG_BIT_COUNT, ($urandom() & ~32'h7FF) | sizes[i]);
			queue_random(BATCH_ITEMS);
		end
		wait_idle();
		repeat (8) @(posedge clk);

		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
